// ----- src/ped_pkg.sv -----
// shared types and constants for the palette expand / pixel doubler block
// no dependencies
package ped_pkg;

  localparam int PaletteDepth = 256;
  localparam int MaxWidth     = 2048;
  localparam int MaxRows      = 2048;
  localparam int OutDepth     = 4;

  localparam int AddrW  = $clog2(PaletteDepth);
  localparam int ColW   = $clog2(MaxWidth);
  localparam int RowW   = $clog2(MaxRows);
  localparam int OutPtrW = $clog2(OutDepth);

  // field widths of the channels
  localparam int ModeW   = 2;
  localparam int IndexW  = 8;
  localparam int ColorW  = 32;
  localparam int BytesW  = 3;
  localparam int DRowW   = 12;
  localparam int OffW    = 14;
  localparam int RwW     = 12;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 12;

  // input item modes
  localparam logic [ModeW-1:0] MODE_PIXEL       = 2'd0;
  localparam logic [ModeW-1:0] MODE_PAL_WRITE   = 2'd1;
  localparam logic [ModeW-1:0] MODE_FRAME_START = 2'd2;

  // pixel size codes, anything else is four bytes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PIXEL_SIZE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SCALE       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PALETTE     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BIG_ENDIAN  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ROW_WIDTH   = 3'd4;

  localparam logic [RwW-1:0]    RowWidthReset = 12'd320;
  localparam logic [BytesW-1:0] BytesOne      = 3'd1;
  localparam logic [BytesW-1:0] BytesFour     = 3'd4;

  typedef struct packed {
    logic [1:0]     pixel_size_code;
    logic           scale_enable;
    logic           palette_enable;
    logic           big_endian;
    logic [RwW-1:0] row_width;
  } cfg_t;

  typedef struct packed {
    logic [ColorW-1:0] data_word;
    logic [BytesW-1:0] bytes_valid;
    logic [DRowW-1:0]  dest_row;
    logic [OffW-1:0]   dest_byte_offset;
    logic              both_rows;
    logic              last_of_item;
  } out_beat_t;

  typedef struct packed {
    logic res_valid;
    logic more;
  } core_status_t;

endpackage

// ----- src/ped_channels_if.sv -----
// valid/ready channel interfaces: pixel feed, result words, config writes
// depends on ped_pkg
interface ped_in_if;
  logic                      valid;
  logic                      ready;
  logic [ped_pkg::ModeW-1:0]  mode;
  logic [ped_pkg::IndexW-1:0] pixel_index;
  logic [ped_pkg::AddrW-1:0]  palette_addr;
  logic [ped_pkg::ColorW-1:0] palette_value;

  modport source(output valid, mode, pixel_index, palette_addr, palette_value, input ready);
  modport sink(input valid, mode, pixel_index, palette_addr, palette_value, output ready);
endinterface

interface ped_out_if;
  logic                      valid;
  logic                      ready;
  logic [ped_pkg::ColorW-1:0] data_word;
  logic [ped_pkg::BytesW-1:0] bytes_valid;
  logic [ped_pkg::DRowW-1:0]  dest_row;
  logic [ped_pkg::OffW-1:0]   dest_byte_offset;
  logic                      both_rows;
  logic                      last_of_item;

  modport source(output valid, data_word, bytes_valid, dest_row, dest_byte_offset,
                 both_rows, last_of_item, input ready);
  modport sink(input valid, data_word, bytes_valid, dest_row, dest_byte_offset,
               both_rows, last_of_item, output ready);
endinterface

interface ped_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ped_pkg::CfgIdxW-1:0] index;
  logic [ped_pkg::CfgDatW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- src/ped_palette_ram.sv -----
// palette storage, one write port and one registered read port
// depends on ped_pkg
module ped_palette_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ped_pkg::AddrW-1:0]  waddr,
  input  logic [ped_pkg::ColorW-1:0] wdata,
  input  logic                       re,
  input  logic [ped_pkg::AddrW-1:0]  raddr,
  output logic [ped_pkg::ColorW-1:0] rdata
);

  logic [ped_pkg::ColorW-1:0] mem [ped_pkg::PaletteDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/ped_pixel_core.sv -----
// pixel formatter: pending pixel, column and row counters, result word forming
// depends on ped_pkg
module ped_pixel_core (
  input  logic                       clk,
  input  logic                       rst,
  input  ped_pkg::cfg_t              cfg,
  input  logic [ped_pkg::ModeW-1:0]  mode,
  input  logic [ped_pkg::IndexW-1:0] idx,
  input  logic [ped_pkg::ColorW-1:0] entry,
  input  logic                       second,
  input  logic                       step,
  output ped_pkg::core_status_t      status,
  output ped_pkg::out_beat_t         beat
);

  logic [15:0]              pending_pixel;
  logic                     pending_valid;
  logic [ped_pkg::ColW-1:0] column_count;
  logic [ped_pkg::RowW-1:0] row_count;

  logic [ped_pkg::RwW-1:0]  width_eff;
  logic                     final_col;
  logic                     is_pixel;
  logic                     size_byte;
  logic                     size_half;
  logic                     paired;
  logic                     two_words;
  logic [15:0]              v16;
  logic [15:0]              pa;
  logic [15:0]              pb;
  logic [ped_pkg::OffW-1:0] col_off;
  logic                     done;

  always_comb begin
    width_eff = cfg.row_width;
    if (cfg.row_width == '0) begin
      width_eff = ped_pkg::RwW'(1);
    end else if (cfg.row_width > ped_pkg::RwW'(ped_pkg::MaxWidth)) begin
      width_eff = ped_pkg::RwW'(ped_pkg::MaxWidth);
    end
  end

  assign final_col = (ped_pkg::RwW'(column_count) + ped_pkg::RwW'(1)) >= width_eff;
  assign is_pixel  = (mode == ped_pkg::MODE_PIXEL);
  assign size_byte = (cfg.pixel_size_code == ped_pkg::SIZE_BYTE);
  assign size_half = (cfg.pixel_size_code == ped_pkg::SIZE_HALF);
  assign paired    = cfg.scale_enable ? size_byte : (cfg.palette_enable && size_half);
  assign two_words = cfg.scale_enable && !size_byte && !size_half;
  assign v16       = cfg.scale_enable ? {8'h00, idx} : entry[15:0];
  assign col_off   = ped_pkg::OffW'(column_count);

  // earlier pixel in a, later in b; a lone last pixel pairs with zero
  assign pa = pending_valid ? pending_pixel : v16;
  assign pb = pending_valid ? v16 : 16'h0000;

  always_comb begin
    status.res_valid = is_pixel && (!paired || pending_valid || final_col);
    status.more      = is_pixel && !paired && two_words && !second;

    beat.bytes_valid      = ped_pkg::BytesFour;
    beat.dest_row         = cfg.scale_enable ? ped_pkg::DRowW'({row_count, 1'b0})
                                             : ped_pkg::DRowW'(row_count);
    beat.both_rows        = cfg.scale_enable;
    beat.last_of_item     = !status.more;
    beat.data_word        = entry;
    beat.dest_byte_offset = col_off << 2;

    priority if (paired) begin
      beat.dest_byte_offset = pending_valid ? ped_pkg::OffW'((col_off - 14'd1) << 1)
                                            : ped_pkg::OffW'(col_off << 1);
      if (cfg.scale_enable) begin
        beat.data_word = cfg.big_endian ? {pa[7:0], pa[7:0], pb[7:0], pb[7:0]}
                                        : {pb[7:0], pb[7:0], pa[7:0], pa[7:0]};
      end else begin
        beat.data_word = {pb, pa};
      end
    end else if (cfg.scale_enable) begin
      if (size_half) begin
        beat.data_word        = {entry[15:0], entry[15:0]};
        beat.dest_byte_offset = ped_pkg::OffW'(col_off << 2);
      end else begin
        beat.data_word        = entry;
        beat.dest_byte_offset = ped_pkg::OffW'((col_off << 3) + (second ? 14'd4 : 14'd0));
      end
    end else if (cfg.palette_enable) begin
      if (size_byte) begin
        beat.data_word   = {24'h000000, entry[7:0]};
        beat.bytes_valid = ped_pkg::BytesOne;
        beat.dest_byte_offset = col_off;
      end else begin
        beat.data_word        = entry;
        beat.dest_byte_offset = ped_pkg::OffW'(col_off << 2);
      end
    end else begin
      beat.data_word        = {24'h000000, idx};
      beat.bytes_valid      = ped_pkg::BytesOne;
      beat.dest_byte_offset = col_off;
    end
  end

  // state moves once per item, on its last step
  assign done = step && !status.more;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_pixel <= '0;
      pending_valid <= 1'b0;
      column_count  <= '0;
      row_count     <= '0;
    end else if (done) begin
      if (mode == ped_pkg::MODE_FRAME_START) begin
        pending_pixel <= '0;
        pending_valid <= 1'b0;
        column_count  <= '0;
        row_count     <= '0;
      end else if (is_pixel) begin
        if (paired && !pending_valid && !final_col) begin
          pending_pixel <= v16;
          pending_valid <= 1'b1;
        end else begin
          pending_valid <= 1'b0;
        end
        if (final_col) begin
          column_count <= '0;
          row_count    <= (row_count == ped_pkg::RowW'(ped_pkg::MaxRows - 1))
                          ? '0 : row_count + ped_pkg::RowW'(1);
        end else begin
          column_count <= column_count + ped_pkg::ColW'(1);
        end
      end
    end
  end

endmodule

// ----- src/ped_out_fifo.sv -----
// small result queue that drives the output channel
// depends on ped_pkg and ped_out_if
module ped_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ped_pkg::out_beat_t push_beat,
  output logic               full,
  ped_out_if.source          dst
);

  ped_pkg::out_beat_t            slots [ped_pkg::OutDepth];
  logic [ped_pkg::OutPtrW-1:0]   wr_ptr;
  logic [ped_pkg::OutPtrW-1:0]   rd_ptr;
  logic [ped_pkg::OutPtrW:0]     count;
  logic                          pop;
  logic                          do_push;
  ped_pkg::out_beat_t            head;

  assign full    = (count == (ped_pkg::OutPtrW+1)'(ped_pkg::OutDepth));
  assign do_push = push && !full;
  assign pop     = dst.valid && dst.ready;
  assign head    = slots[rd_ptr];

  assign dst.valid            = (count != '0);
  assign dst.data_word        = head.data_word;
  assign dst.bytes_valid      = head.bytes_valid;
  assign dst.dest_row         = head.dest_row;
  assign dst.dest_byte_offset = head.dest_byte_offset;
  assign dst.both_rows        = head.both_rows;
  assign dst.last_of_item     = head.last_of_item;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + ped_pkg::OutPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + ped_pkg::OutPtrW'(1);
      end
      if (do_push && !pop) begin
        count <= count + (ped_pkg::OutPtrW+1)'(1);
      end else if (pop && !do_push) begin
        count <= count - (ped_pkg::OutPtrW+1)'(1);
      end
    end
  end

endmodule

// ----- src/palette_expand_pixel_doubler.sv -----
// top level of the palette expand / pixel doubler
// depends on ped_pkg, ped_channels_if, ped_palette_ram, ped_pixel_core, ped_out_fifo
//
// Takes one item per clock on feed, unless the core is held by a full queue or a
// two-word pixel: a pixel index, a palette write or a start of frame. The palette
// read for a pixel happens on the beat that accepts it, so the item and its color
// meet in the next cycle, where the core forms the result word and updates the
// pending pixel and the column and row counters. The core pushes one result word per
// cycle into a four-deep output queue while it has room, so pixels that give zero or
// one word go at one per clock; a pixel in 32-bit scale mode gives two words and
// holds the core until both are pushed. Feed ready depends only on internal state,
// never combinationally on result ready. Palette writes land on their accept beat and
// are seen by any pixel accepted after them. Configuration writes are taken on every
// cycle and must only happen while the block is idle. The palette comes out of reset
// undefined; pixels must only look up entries already written.
module palette_expand_pixel_doubler (
  input  logic       clk,
  input  logic       rst,
  ped_in_if.sink     feed,
  ped_out_if.source  result,
  ped_cfg_if.sink    cfg
);

  ped_pkg::cfg_t                  cfg_regs;

  // stage 1: item waiting for the core
  logic                           s1_valid;
  logic [ped_pkg::ModeW-1:0]      s1_mode;
  logic [ped_pkg::IndexW-1:0]     s1_idx;
  logic                           second;
  logic [ped_pkg::ColorW-1:0]     entry;

  logic                           feed_beat;
  logic                           step;
  logic                           s1_done;
  logic                           queue_full;
  ped_pkg::core_status_t          status;
  ped_pkg::out_beat_t             beat;

  // config port never stalls
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.pixel_size_code <= '0;
      cfg_regs.scale_enable    <= 1'b0;
      cfg_regs.palette_enable  <= 1'b0;
      cfg_regs.big_endian      <= 1'b0;
      cfg_regs.row_width       <= ped_pkg::RowWidthReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ped_pkg::REG_PIXEL_SIZE: cfg_regs.pixel_size_code <= cfg.data[1:0];
        ped_pkg::REG_SCALE:      cfg_regs.scale_enable    <= cfg.data[0];
        ped_pkg::REG_PALETTE:    cfg_regs.palette_enable  <= cfg.data[0];
        ped_pkg::REG_BIG_ENDIAN: cfg_regs.big_endian      <= cfg.data[0];
        ped_pkg::REG_ROW_WIDTH:  cfg_regs.row_width       <= cfg.data[ped_pkg::RwW-1:0];
        default: ;
      endcase
    end
  end

  // the core moves when it has no word to push or the queue has room
  assign step      = s1_valid && (!status.res_valid || !queue_full);
  assign s1_done   = step && !status.more;
  assign feed.ready = !s1_valid || s1_done;
  assign feed_beat = feed.valid && feed.ready;

  ped_palette_ram u_palette (
    .clk   (clk),
    .we    (feed_beat && (feed.mode == ped_pkg::MODE_PAL_WRITE)),
    .waddr (feed.palette_addr),
    .wdata (feed.palette_value),
    .re    (feed_beat),
    .raddr (feed.pixel_index),
    .rdata (entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      second   <= 1'b0;
    end else begin
      if (feed.ready) begin
        s1_valid <= feed.valid;
      end
      if (s1_done) begin
        second <= 1'b0;
      end else if (step) begin
        second <= 1'b1;
      end
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk) begin
    if (feed_beat) begin
      s1_mode <= feed.mode;
      s1_idx  <= feed.pixel_index;
    end
  end

  ped_pixel_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_regs),
    .mode   (s1_mode),
    .idx    (s1_idx),
    .entry  (entry),
    .second (second),
    .step   (step),
    .status (status),
    .beat   (beat)
  );

  ped_out_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (step && status.res_valid),
    .push_beat (beat),
    .full      (queue_full),
    .dst       (result)
  );

endmodule
